FILE: hdl/bvreg_pkg.sv
`timescale 1ns / 1ps
// Shared constants, configuration types and microcode types of the bus voltage regulator.
// No dependencies; every other file imports this package.
package bvreg_pkg;

   localparam int SAMPLE_COUNT = 5;
   localparam int ADC_BITS     = 12;
   localparam int INPUT_FIELDS = 5;
   localparam int ADC_FIELD_W  = 12;

   localparam int TAKE_N  = (SAMPLE_COUNT < INPUT_FIELDS) ? SAMPLE_COUNT : INPUT_FIELDS;
   localparam int ADC_W   = (ADC_BITS < ADC_FIELD_W) ? ADC_BITS : ADC_FIELD_W;
   localparam int SUM_W   = ADC_W + $clog2(TAKE_N);

   localparam int VOLT_W  = 23;
   localparam int ERR_W   = 24;
   localparam int GAIN_W  = 20;
   localparam int COEF_W  = 22;
   localparam int VPS_W   = 24;
   localparam int PER_W   = 16;
   localparam int FRAC_W  = 16;
   localparam int LIMIT_W = PER_W + FRAC_W;
   localparam int CMP_W   = 16;
   localparam int CMP_LSB = 24;
   localparam int Y_W     = 48;
   localparam int MUL_W   = 25;
   localparam int PROD_W  = 2 * MUL_W;
   localparam int ACC_W   = 50;
   localparam int VPROD_W = SUM_W + VPS_W;
   localparam int RND_SH  = 8;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int STEP_W     = 4;

   localparam logic [1:0] CLAMP_NONE = 2'd0;
   localparam logic [1:0] CLAMP_HIGH = 2'd1;
   localparam logic [1:0] CLAMP_LOW  = 2'd2;

   typedef enum logic [2:0] {
      CSR_TARGET   = 3'd0,
      CSR_PROP     = 3'd1,
      CSR_INTEG    = 3'd2,
      CSR_DERIV    = 3'd3,
      CSR_VPS      = 3'd4,
      CSR_PERIOD   = 3'd5,
      CSR_UPPER    = 3'd6,
      CSR_LOWER    = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic        [VOLT_W-1:0] target;
      logic signed [GAIN_W-1:0] kp;
      logic signed [GAIN_W-1:0] ki;
      logic signed [GAIN_W-1:0] kd;
      logic        [VPS_W-1:0]  vps;
      logic        [PER_W-1:0]  period;
      logic        [FRAC_W-1:0] upper_frac;
      logic        [FRAC_W-1:0] lower_frac;
   } cfg_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] a0;
      logic signed [COEF_W-1:0] a1;
   } coef_type;

   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_VOLT,
      MUL_UPPER,
      MUL_LOWER,
      MUL_P0,
      MUL_P1,
      MUL_P2
   } mul_sel_type;

   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_VOLT,
      ACT_ERR,
      ACT_LOAD,
      ACT_ADD,
      ACT_SAT,
      ACT_CLAMP_HI,
      ACT_CLAMP_LO,
      ACT_EMIT
   } act_type;

   typedef enum logic [1:0] {
      JMP_NEXT,
      JMP_COND,
      JMP_END
   } jump_type;

   typedef struct packed {
      mul_sel_type mul;
      act_type     act;
   } ctrl_type;

   typedef struct packed {
      ctrl_type            ctrl;
      jump_type            jmp;
      logic [STEP_W-1:0]   target;
   } ucode_type;

   typedef struct packed {
      logic cond_high;
      logic out_full;
   } status_type;

endpackage

FILE: hdl/bvreg_req_if.sv
`timescale 1ns / 1ps
// Request channel: one burst of ADC conversions with valid/ready handshake.
// Depends on bvreg_pkg for field widths.
interface bvreg_req_if;
   import bvreg_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [ADC_FIELD_W-1:0] sample_a;
   logic [ADC_FIELD_W-1:0] sample_b;
   logic [ADC_FIELD_W-1:0] sample_c;
   logic [ADC_FIELD_W-1:0] sample_d;
   logic [ADC_FIELD_W-1:0] sample_e;

   modport source (output valid, sample_a, sample_b, sample_c, sample_d, sample_e,
                   input ready);
   modport sink (input valid, sample_a, sample_b, sample_c, sample_d, sample_e,
                 output ready);
endinterface

FILE: hdl/bvreg_rsp_if.sv
`timescale 1ns / 1ps
// Result channel: compare count, measured voltage, error and clamp flag with valid/ready.
// Depends on bvreg_pkg for field widths.
interface bvreg_rsp_if;
   import bvreg_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [CMP_W-1:0]        compare_value;
   logic [VOLT_W-1:0]       bus_voltage;
   logic signed [ERR_W-1:0] error_value;
   logic [1:0]              clamp_state;

   modport source (output valid, compare_value, bus_voltage, error_value, clamp_state,
                   input ready);
   modport sink (input valid, compare_value, bus_voltage, error_value, clamp_state,
                 output ready);
endinterface

FILE: hdl/bvreg_csr.sv
`timescale 1ns / 1ps
// APB-style configuration registers and the derived PID coefficients.
// Depends on bvreg_pkg.
module bvreg_csr import bvreg_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg,
   output coef_type              coef
);

   cfg_type       cfg_ff, cfg_in;
   coef_type      coef_ff, coef_in;
   csr_index_type index;
   logic          wr_en;

   assign index      = csr_index_type'(csr_paddr[4:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            CSR_TARGET: cfg_in.target     = csr_pwdata[VOLT_W-1:0];
            CSR_PROP:   cfg_in.kp         = csr_pwdata[GAIN_W-1:0];
            CSR_INTEG:  cfg_in.ki         = csr_pwdata[GAIN_W-1:0];
            CSR_DERIV:  cfg_in.kd         = csr_pwdata[GAIN_W-1:0];
            CSR_VPS:    cfg_in.vps        = csr_pwdata[VPS_W-1:0];
            CSR_PERIOD: cfg_in.period     = csr_pwdata[PER_W-1:0];
            CSR_UPPER:  cfg_in.upper_frac = csr_pwdata[FRAC_W-1:0];
            CSR_LOWER:  cfg_in.lower_frac = csr_pwdata[FRAC_W-1:0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   // a0 = Kp + Ki + Kd, a1 = -(Kp + 2 Kd)
   always_comb begin
      coef_in.a0 = COEF_W'(cfg_ff.kp) + COEF_W'(cfg_ff.ki) + COEF_W'(cfg_ff.kd);
      coef_in.a1 = -(COEF_W'(cfg_ff.kp) + (COEF_W'(cfg_ff.kd) <<< 1));
   end

   always_comb begin
      case (index)
         CSR_TARGET: csr_prdata = CSR_DATA_W'(cfg_ff.target);
         CSR_PROP:   csr_prdata = CSR_DATA_W'(unsigned'(cfg_ff.kp));
         CSR_INTEG:  csr_prdata = CSR_DATA_W'(unsigned'(cfg_ff.ki));
         CSR_DERIV:  csr_prdata = CSR_DATA_W'(unsigned'(cfg_ff.kd));
         CSR_VPS:    csr_prdata = CSR_DATA_W'(cfg_ff.vps);
         CSR_PERIOD: csr_prdata = CSR_DATA_W'(cfg_ff.period);
         CSR_UPPER:  csr_prdata = CSR_DATA_W'(cfg_ff.upper_frac);
         CSR_LOWER:  csr_prdata = CSR_DATA_W'(cfg_ff.lower_frac);
         default:    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target     <= VOLT_W'(1966080);
         cfg_ff.kp         <= GAIN_W'(-25600);
         cfg_ff.ki         <= GAIN_W'(25600);
         cfg_ff.kd         <= '0;
         cfg_ff.vps        <= VPS_W'(58983);
         cfg_ff.period     <= PER_W'(65503);
         cfg_ff.upper_frac <= FRAC_W'(64225);
         cfg_ff.lower_frac <= FRAC_W'(22938);
      end else begin
         cfg_ff <= cfg_in;
      end
      coef_ff <= coef_in;
   end

   assign cfg  = cfg_ff;
   assign coef = coef_ff;

endmodule

FILE: hdl/bvreg_seq.sv
`timescale 1ns / 1ps
// Microcode sequencer: program ROM, step counter and conditional jumps.
// Depends on bvreg_pkg and bvreg_req_if.
module bvreg_seq import bvreg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   bvreg_req_if.sink   req_if,
   input  status_type  status,
   output ctrl_type    ctrl
);

   localparam logic [STEP_W-1:0] ST_SCALE   = 4'd0;
   localparam logic [STEP_W-1:0] ST_VOLT    = 4'd1;
   localparam logic [STEP_W-1:0] ST_ERR     = 4'd2;
   localparam logic [STEP_W-1:0] ST_LOAD    = 4'd3;
   localparam logic [STEP_W-1:0] ST_ADD0    = 4'd4;
   localparam logic [STEP_W-1:0] ST_ADD1    = 4'd5;
   localparam logic [STEP_W-1:0] ST_ADD2    = 4'd6;
   localparam logic [STEP_W-1:0] ST_SAT     = 4'd7;
   localparam logic [STEP_W-1:0] ST_CLAMPHI = 4'd8;
   localparam logic [STEP_W-1:0] ST_CLAMPLO = 4'd9;
   localparam logic [STEP_W-1:0] ST_EMIT    = 4'd10;

   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_type word;
      word = '{ctrl: '{mul: MUL_NONE, act: ACT_NONE}, jmp: JMP_END, target: ST_SCALE};
      case (step)
         ST_SCALE:   word = '{'{MUL_VOLT,  ACT_NONE},     JMP_NEXT, ST_SCALE};
         ST_VOLT:    word = '{'{MUL_UPPER, ACT_VOLT},     JMP_NEXT, ST_SCALE};
         ST_ERR:     word = '{'{MUL_LOWER, ACT_ERR},      JMP_NEXT, ST_SCALE};
         ST_LOAD:    word = '{'{MUL_P0,    ACT_LOAD},     JMP_NEXT, ST_SCALE};
         ST_ADD0:    word = '{'{MUL_P1,    ACT_ADD},      JMP_NEXT, ST_SCALE};
         ST_ADD1:    word = '{'{MUL_P2,    ACT_ADD},      JMP_NEXT, ST_SCALE};
         ST_ADD2:    word = '{'{MUL_NONE,  ACT_ADD},      JMP_NEXT, ST_SCALE};
         ST_SAT:     word = '{'{MUL_NONE,  ACT_SAT},      JMP_NEXT, ST_SCALE};
         ST_CLAMPHI: word = '{'{MUL_NONE,  ACT_CLAMP_HI}, JMP_COND, ST_EMIT};
         ST_CLAMPLO: word = '{'{MUL_NONE,  ACT_CLAMP_LO}, JMP_NEXT, ST_SCALE};
         ST_EMIT:    word = '{'{MUL_NONE,  ACT_EMIT},     JMP_END,  ST_SCALE};
         default:    word = '{'{MUL_NONE,  ACT_NONE},     JMP_END,  ST_SCALE};
      endcase
      return word;
   endfunction

   logic              busy_ff, busy_in;
   logic [STEP_W-1:0] step_ff, step_in;
   ucode_type         word;
   logic              stall;
   logic              accept;

   assign req_if.ready = ~busy_ff;
   assign accept       = req_if.valid & req_if.ready;
   assign word         = ucode_rom(step_ff);
   assign stall        = (word.ctrl.act == ACT_EMIT) && status.out_full;

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      if (accept) begin
         busy_in = 1'b1;
         step_in = ST_SCALE;
      end else if (busy_ff && !stall) begin
         case (word.jmp)
            JMP_NEXT: step_in = step_ff + 1'b1;
            JMP_COND: step_in = status.cond_high ? word.target : step_ff + 1'b1;
            JMP_END:  busy_in = 1'b0;
            default:  busy_in = 1'b0;
         endcase
      end
   end

   always_comb begin
      ctrl = word.ctrl;
      if (!busy_ff || stall) begin
         ctrl.act = ACT_NONE;
         ctrl.mul = MUL_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= ST_SCALE;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

endmodule

FILE: hdl/bvreg_dp.sv
`timescale 1ns / 1ps
// Datapath: sample sum, shared multiplier, PID accumulator, clamp and result register.
// Depends on bvreg_pkg, bvreg_req_if and bvreg_rsp_if.
module bvreg_dp import bvreg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   bvreg_req_if.sink   req_if,
   bvreg_rsp_if.source rsp_if,
   input  cfg_type     cfg,
   input  coef_type    coef,
   input  ctrl_type    ctrl,
   output status_type  status
);

   logic [ADC_FIELD_W-1:0]   samples [INPUT_FIELDS];
   logic [SUM_W-1:0]         sum_ff, sum_in;
   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] prod_ff;
   logic [VOLT_W-1:0]        volt_ff;
   logic signed [ERR_W-1:0]  err_ff;
   logic [LIMIT_W-1:0]       upper_ff, lower_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [Y_W-1:0]    last_output_ff;
   logic signed [ERR_W-1:0]  last_error_ff, older_error_ff;
   logic [CMP_W-1:0]         cmp_ff;
   logic [1:0]               flag_ff;
   logic                     rsp_valid_ff;
   logic [CMP_W-1:0]         rsp_cmp_ff;
   logic [VOLT_W-1:0]        rsp_volt_ff;
   logic signed [ERR_W-1:0]  rsp_err_ff;
   logic [1:0]               rsp_flag_ff;

   logic [VPROD_W:0]           rnd;
   logic [VPROD_W-RND_SH:0]    scaled;
   logic [VOLT_W-1:0]          volt_in;
   logic                       acc_fits;
   logic signed [Y_W-1:0]      y_sat;
   logic signed [Y_W-1:0]      lim_hi, lim_lo;
   logic                       accept;

   assign samples[0] = req_if.sample_a;
   assign samples[1] = req_if.sample_b;
   assign samples[2] = req_if.sample_c;
   assign samples[3] = req_if.sample_d;
   assign samples[4] = req_if.sample_e;
   assign accept     = req_if.valid & req_if.ready;

   always_comb begin
      sum_in = '0;
      for (int i = 0; i < TAKE_N; i++) begin
         sum_in = sum_in + SUM_W'(samples[i][ADC_W-1:0]);
      end
   end

   always_comb begin
      case (ctrl.mul)
         MUL_VOLT:  begin mul_a = MUL_W'(sum_ff);        mul_b = MUL_W'(cfg.vps);        end
         MUL_UPPER: begin mul_a = MUL_W'(cfg.period);    mul_b = MUL_W'(cfg.upper_frac); end
         MUL_LOWER: begin mul_a = MUL_W'(cfg.period);    mul_b = MUL_W'(cfg.lower_frac); end
         MUL_P0:    begin mul_a = MUL_W'(coef.a0);       mul_b = MUL_W'(err_ff);         end
         MUL_P1:    begin mul_a = MUL_W'(coef.a1);       mul_b = MUL_W'(last_error_ff);  end
         MUL_P2:    begin mul_a = MUL_W'(cfg.kd);        mul_b = MUL_W'(older_error_ff); end
         default:   begin mul_a = '0;                    mul_b = '0;                     end
      endcase
   end

   // round half up, then saturate to the voltage range
   assign rnd     = (VPROD_W+1)'(prod_ff[VPROD_W-1:0]) + (VPROD_W+1)'(128);
   assign scaled  = rnd[VPROD_W:RND_SH];
   assign volt_in = (|scaled[VPROD_W-RND_SH:VOLT_W]) ? '1 : scaled[VOLT_W-1:0];

   assign acc_fits = (&acc_ff[ACC_W-1:Y_W-1]) || !(|acc_ff[ACC_W-1:Y_W-1]);
   assign y_sat    = acc_fits ? acc_ff[Y_W-1:0] :
                     (acc_ff[ACC_W-1] ? {1'b1, {(Y_W-1){1'b0}}} : {1'b0, {(Y_W-1){1'b1}}});

   assign lim_hi = Y_W'({upper_ff, 8'h00});
   assign lim_lo = Y_W'({lower_ff, 8'h00});

   assign status.cond_high = last_output_ff > lim_hi;
   assign status.out_full  = rsp_valid_ff & ~rsp_if.ready;

   always_ff @(posedge clock) begin
      if (accept) begin
         sum_ff <= sum_in;
      end
      prod_ff <= mul_a * mul_b;
      case (ctrl.act)
         ACT_VOLT: volt_ff <= volt_in;
         ACT_ERR: begin
            err_ff   <= ERR_W'(volt_ff) - ERR_W'(cfg.target);
            upper_ff <= prod_ff[LIMIT_W-1:0];
         end
         ACT_LOAD: begin
            lower_ff <= prod_ff[LIMIT_W-1:0];
            acc_ff   <= ACC_W'(last_output_ff);
         end
         ACT_ADD: acc_ff <= acc_ff + prod_ff;
         ACT_CLAMP_HI: begin
            if (status.cond_high) begin
               cmp_ff  <= upper_ff[LIMIT_W-1:LIMIT_W-CMP_W];
               flag_ff <= CLAMP_HIGH;
            end
         end
         ACT_CLAMP_LO: begin
            if (last_output_ff < lim_lo) begin
               cmp_ff  <= lower_ff[LIMIT_W-1:LIMIT_W-CMP_W];
               flag_ff <= CLAMP_LOW;
            end else begin
               cmp_ff  <= last_output_ff[CMP_LSB+CMP_W-1:CMP_LSB];
               flag_ff <= CLAMP_NONE;
            end
         end
         ACT_EMIT: begin
            rsp_cmp_ff  <= cmp_ff;
            rsp_volt_ff <= volt_ff;
            rsp_err_ff  <= err_ff;
            rsp_flag_ff <= flag_ff;
         end
         default: ;
      endcase

      if (reset) begin
         last_output_ff <= '0;
         last_error_ff  <= '0;
         older_error_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (ctrl.act == ACT_SAT) begin
            last_output_ff <= y_sat;
            last_error_ff  <= err_ff;
            older_error_ff <= last_error_ff;
         end
         if (ctrl.act == ACT_EMIT) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.compare_value = rsp_cmp_ff;
   assign rsp_if.bus_voltage   = rsp_volt_ff;
   assign rsp_if.error_value   = rsp_err_ff;
   assign rsp_if.clamp_state   = rsp_flag_ff;

endmodule

FILE: hdl/bus_voltage_pid_pwm_regulator.sv
`timescale 1ns / 1ps
// Top level of the bus voltage PID regulator with PWM compare output.
// Depends on bvreg_pkg, bvreg_req_if, bvreg_rsp_if, bvreg_csr, bvreg_seq and bvreg_dp.
//
//   channel   direction  handshake               payload
//   req_if    in         valid/ready             sample_a .. sample_e
//   rsp_if    out        valid/ready             compare_value, bus_voltage,
//                                                error_value, clamp_state
//   csr_*     in         APB setup/access        registers 0..7 at 4*index
//
// A request runs an 11-step microprogram over one shared 25x25 multiplier; its result
// loads the output register at the final emit step; the low-clamp step is skipped when
// the output clamps high. Ready returns the cycle after the result loads, so a new request
// waits for the previous result. Reset is synchronous and clears the
// sequencer, the PID history and the output valid. A stalled output register holds
// the program at its last step; a new request is taken once the result is loaded.
module bus_voltage_pid_pwm_regulator import bvreg_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   bvreg_req_if.sink             req_if,
   bvreg_rsp_if.source           rsp_if,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type    cfg;
   coef_type   coef;
   ctrl_type   ctrl;
   status_type status;

   bvreg_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg),
      .coef        (coef)
   );

   bvreg_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .status (status),
      .ctrl   (ctrl)
   );

   bvreg_dp u_dp (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .cfg    (cfg),
      .coef   (coef),
      .ctrl   (ctrl),
      .status (status)
   );

endmodule
